// ===== rtl/cwrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwrt_pkg
// Shared types for the contiguous write range tracker.
// ----------------------------------------------------------------------------
package cwrt_pkg;

	localparam int OFF_W = 48;
	localparam int END_W = 49;
	localparam int LEN_W = 32;
	localparam int MSG_W = 48;
	localparam int CNT_W = 32;

	typedef enum logic [1:0] {
		ST_MERGED   = 2'd0,
		ST_ZERO_LEN = 2'd1,
		ST_FULL     = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic [OFF_W-1:0] offset;
		logic [END_W-1:0] wend;
		logic [CNT_W-1:0] msgs;
		status_t          kind;
	} req_t;

	typedef struct packed {
		logic [OFF_W-1:0] rstart;
		logic [END_W-1:0] rend;
		logic [MSG_W-1:0] rmsgs;
	} range_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_PROC,
		BK_FINISH,
		BK_COMMIT
	} bk_state_t;

endpackage
`default_nettype wire

// ===== rtl/cwrt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwrt_front
// Accepts write requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module cwrt_front #(
	parameter int OFFSET_BITS = 48
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [cwrt_pkg::OFF_W-1:0]       write_offset,
	input  wire  [cwrt_pkg::LEN_W-1:0]       write_length,
	input  wire  [cwrt_pkg::CNT_W-1:0]       message_count,
	output logic                             req_valid,
	input  wire                              req_pop,
	output cwrt_pkg::req_t                   req
);
	import cwrt_pkg::*;

	localparam logic [63:0] END_LIMIT = (64'd1 << OFFSET_BITS) - 64'd1;

	req_t       q_mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic [END_W-1:0] sum;
	req_t       new_req;
	logic       push;

	assign sum = END_W'(write_offset) + END_W'(write_length);

	always_comb begin
		new_req.offset = write_offset;
		new_req.wend   = sum;
		new_req.msgs   = message_count;
		if (write_length == '0) begin
			new_req.kind = ST_ZERO_LEN;
		end else if (64'(sum) > END_LIMIT) begin
			new_req.kind = ST_OVERFLOW;
		end else begin
			new_req.kind = ST_MERGED;
		end
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign req_valid = (cnt_q != 2'd0);
	assign req       = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wp_q] <= new_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (req_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(req_pop);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cwrt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwrt_back
// Merge engine: streams the sorted range table from one bank into the other,
// folding in the request, and reports the range that starts at zero.
// ----------------------------------------------------------------------------
module cwrt_back #(
	parameter int MAX_RANGES = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              req_valid,
	output logic                             req_pop,
	input  cwrt_pkg::req_t                   req,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [cwrt_pkg::OFF_W-1:0]       prefix_end,
	output logic [cwrt_pkg::MSG_W-1:0]       prefix_messages,
	output logic [1:0]                       status
);
	import cwrt_pkg::*;

	localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_RANGES);
	localparam logic [MSG_W:0] MSG_MAX = {1'b0, {MSG_W{1'b1}}};

	range_t mem [2**(IW+1)];
	range_t rd_data_q;

	bk_state_t state_q, state_d;
	logic            bank_q;
	logic [CW-1:0]   used_q;
	logic [CW-1:0]   rd_idx_q, rd_idx_d;
	logic [CW-1:0]   wr_idx_q, wr_idx_d;
	logic            ins_q, ins_d;
	logic            mrg_q, mrg_d;
	logic [OFF_W-1:0] off_q;
	range_t          new_q, new_d;
	range_t          first_q;
	logic            pfx_vld_q;
	logic [OFF_W-1:0] pfx_end_q;
	logic [MSG_W-1:0] pfx_msg_q;

	logic            out_valid_q;
	logic [OFF_W-1:0] out_end_q;
	logic [MSG_W-1:0] out_msg_q;
	status_t         out_st_q;

	logic            rd_en;
	logic            wr_en;
	range_t          wr_data;
	logic [MSG_W:0]  msum;
	logic            load_out;
	status_t         load_st;
	logic            commit;
	logic            drop;

	assign msum = {1'b0, new_q.rmsgs} + {1'b0, rd_data_q.rmsgs};
	assign drop = !mrg_q && (used_q == MAX_C);

	always_comb begin
		state_d  = state_q;
		rd_idx_d = rd_idx_q;
		wr_idx_d = wr_idx_q;
		ins_d    = ins_q;
		mrg_d    = mrg_q;
		new_d    = new_q;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_data  = new_q;
		req_pop  = 1'b0;
		load_out = 1'b0;
		load_st  = ST_MERGED;
		commit   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (req_valid && !out_valid_q) begin
					req_pop = 1'b1;
					if (req.kind != ST_MERGED) begin
						load_out = 1'b1;
						load_st  = req.kind;
					end else begin
						new_d.rstart = req.offset;
						new_d.rend   = req.wend;
						new_d.rmsgs  = MSG_W'(req.msgs);
						rd_idx_d = '0;
						wr_idx_d = '0;
						ins_d    = 1'b0;
						mrg_d    = 1'b0;
						state_d  = (used_q == '0) ? BK_FINISH : BK_READ;
					end
				end
			end
			BK_READ: begin
				rd_en   = 1'b1;
				state_d = BK_PROC;
			end
			BK_PROC: begin
				if (ins_q || (rd_data_q.rend < END_W'(off_q))) begin
					wr_en    = 1'b1;
					wr_data  = rd_data_q;
					wr_idx_d = wr_idx_q + 1'b1;
					rd_idx_d = rd_idx_q + 1'b1;
					state_d  = (rd_idx_d == used_q) ? BK_FINISH : BK_READ;
				end else if (END_W'(rd_data_q.rstart) <= new_q.rend) begin
					mrg_d = 1'b1;
					if (rd_data_q.rstart < new_q.rstart) begin
						new_d.rstart = rd_data_q.rstart;
					end
					if (rd_data_q.rend > new_q.rend) begin
						new_d.rend = rd_data_q.rend;
					end
					new_d.rmsgs = (msum > MSG_MAX) ? MSG_MAX[MSG_W-1:0] : msum[MSG_W-1:0];
					rd_idx_d = rd_idx_q + 1'b1;
					state_d  = (rd_idx_d == used_q) ? BK_FINISH : BK_READ;
				end else begin
					wr_en    = 1'b1;
					wr_idx_d = wr_idx_q + 1'b1;
					ins_d    = 1'b1;
				end
			end
			BK_FINISH: begin
				if (!ins_q) begin
					wr_en    = 1'b1;
					wr_idx_d = wr_idx_q + 1'b1;
				end
				state_d = BK_COMMIT;
			end
			BK_COMMIT: begin
				load_out = 1'b1;
				load_st  = drop ? ST_FULL : ST_MERGED;
				commit   = !drop;
				state_d  = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
		if (wr_idx_q >= MAX_C) begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{~bank_q, wr_idx_q[IW-1:0]}] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[{bank_q, rd_idx_q[IW-1:0]}];
		end
		if (wr_en && (wr_idx_q == '0)) begin
			first_q <= wr_data;
		end
		new_q <= new_d;
		if (req_pop) begin
			off_q <= req.offset;
		end
		if (commit) begin
			pfx_end_q <= first_q.rend[OFF_W-1:0];
			pfx_msg_q <= first_q.rmsgs;
		end
		if (load_out) begin
			out_end_q <= pfx_vld_q ? pfx_end_q : '0;
			out_msg_q <= pfx_vld_q ? pfx_msg_q : '0;
			out_st_q  <= load_st;
			if (commit) begin
				out_end_q <= (first_q.rstart == '0) ? first_q.rend[OFF_W-1:0] : '0;
				out_msg_q <= (first_q.rstart == '0) ? first_q.rmsgs : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			bank_q      <= 1'b0;
			used_q      <= '0;
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			ins_q       <= 1'b0;
			mrg_q       <= 1'b0;
			pfx_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_idx_q <= rd_idx_d;
			wr_idx_q <= wr_idx_d;
			ins_q    <= ins_d;
			mrg_q    <= mrg_d;
			if (commit) begin
				bank_q    <= ~bank_q;
				used_q    <= wr_idx_q;
				pfx_vld_q <= (first_q.rstart == '0);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign prefix_end      = out_end_q;
	assign prefix_messages = out_msg_q;
	assign status          = out_st_q;

endmodule
`default_nettype wire

// ===== rtl/contiguous_write_range_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_write_range_tracker
// Merges completed writes into a sorted table of disjoint byte ranges and
// reports the contiguous prefix from offset zero after every request.
// ----------------------------------------------------------------------------
// Zero-length or overflowing requests are answered from the idle state.
// Other requests walk the N stored ranges one entry at a time, read then
// process, through the single read port of the range memory, with an extra
// process step when the request lands ahead of a stored range, then finish
// and commit. The engine takes a request only when idle with no unaccepted
// result; a two-entry queue ahead of it keeps accepting while it has room.
// Reset: table empty, prefix zero; memory contents need no clearing.
module contiguous_write_range_tracker #(
	parameter int MAX_RANGES  = 64,
	parameter int OFFSET_BITS = 48
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [cwrt_pkg::OFF_W-1:0]       write_offset,
	input  wire  [cwrt_pkg::LEN_W-1:0]       write_length,
	input  wire  [cwrt_pkg::CNT_W-1:0]       message_count,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [cwrt_pkg::OFF_W-1:0]       prefix_end,
	output logic [cwrt_pkg::MSG_W-1:0]       prefix_messages,
	output logic [1:0]                       status
);
	import cwrt_pkg::*;

	logic req_valid;
	logic req_pop;
	req_t req;

	cwrt_front #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.write_offset  (write_offset),
		.write_length  (write_length),
		.message_count (message_count),
		.req_valid     (req_valid),
		.req_pop       (req_pop),
		.req           (req)
	);

	cwrt_back #(
		.MAX_RANGES (MAX_RANGES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_pop         (req_pop),
		.req             (req),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.prefix_end      (prefix_end),
		.prefix_messages (prefix_messages),
		.status          (status)
	);

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the contiguous write range tracker. A directed request table
// covers the extremes, the ignored, dropped and full-table cases and the
// merges. Random bursts of adjacent and overlapping writes follow. Every
// result is checked against a behavioral range-table predictor.
// ----------------------------------------------------------------------------
module tb;
	import cwrt_pkg::*;

	localparam int MAX_R = 64;
	localparam logic [48:0] END_LIMIT = 49'h0_FFFF_FFFF_FFFF;
	localparam logic [48:0] MSG_CAP = 49'h0_FFFF_FFFF_FFFF;

	typedef struct {
		logic [47:0] prefix_end;
		logic [47:0] prefix_messages;
		status_t     status;
	} prefix_t;

	typedef struct {
		logic [47:0] offset;
		logic [31:0] length;
		logic [31:0] count;
		bit          typed;
		prefix_t     want;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [47:0] write_offset;
	logic [31:0] write_length, message_count;
	logic [47:0] prefix_end, prefix_messages;
	logic [1:0] status;

	logic [47:0] tab_start [MAX_R];
	logic [47:0] tab_end [MAX_R];
	logic [47:0] tab_msgs [MAX_R];
	int tab_used;

	prefix_t pending_prefix [$];
	int errors;
	int send_idle_pct, recv_idle_pct;
	row_t rows [$];

	contiguous_write_range_tracker u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.write_offset(write_offset), .write_length(write_length),
		.message_count(message_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.prefix_end(prefix_end), .prefix_messages(prefix_messages),
		.status(status)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic prefix_t merge_write(logic [47:0] off, logic [31:0] len,
			logic [31:0] cnt);
		prefix_t r;
		logic [48:0] nend, nmsg, nstart;
		int p, lo, hi, k, tail;
		r.status = ST_MERGED;
		if (len == 0) begin
			r.status = ST_ZERO_LEN;
		end else if ({1'b0, off} + 49'(len) > END_LIMIT) begin
			r.status = ST_OVERFLOW;
		end else begin
			nstart = 49'(off);
			nend = {1'b0, off} + 49'(len);
			nmsg = 49'(cnt);
			p = 0;
			while (p < tab_used && tab_start[p] <= off)
				p++;
			lo = p;
			if (p > 0 && tab_end[p-1] >= off) begin
				lo = p - 1;
				nstart = 49'(tab_start[lo]);
				if (49'(tab_end[lo]) > nend)
					nend = 49'(tab_end[lo]);
				nmsg = nmsg + 49'(tab_msgs[lo]);
				if (nmsg > MSG_CAP)
					nmsg = MSG_CAP;
			end
			hi = p;
			while (hi < tab_used && 49'(tab_start[hi]) <= nend) begin
				if (49'(tab_end[hi]) > nend)
					nend = 49'(tab_end[hi]);
				nmsg = nmsg + 49'(tab_msgs[hi]);
				if (nmsg > MSG_CAP)
					nmsg = MSG_CAP;
				hi++;
			end
			k = hi - lo;
			if (k == 0 && tab_used >= MAX_R) begin
				r.status = ST_FULL;
			end else begin
				tail = tab_used - hi;
				if (k == 0) begin
					for (int i = tab_used; i > lo; i--) begin
						tab_start[i] = tab_start[i-1];
						tab_end[i] = tab_end[i-1];
						tab_msgs[i] = tab_msgs[i-1];
					end
				end else begin
					for (int i = 0; i < tail; i++) begin
						tab_start[lo+1+i] = tab_start[hi+i];
						tab_end[lo+1+i] = tab_end[hi+i];
						tab_msgs[lo+1+i] = tab_msgs[hi+i];
					end
				end
				tab_start[lo] = nstart[47:0];
				tab_end[lo] = nend[47:0];
				tab_msgs[lo] = nmsg[47:0];
				tab_used = tab_used - k + 1;
			end
		end
		if (tab_used > 0 && tab_start[0] == 0) begin
			r.prefix_end = tab_end[0];
			r.prefix_messages = tab_msgs[0];
		end else begin
			r.prefix_end = '0;
			r.prefix_messages = '0;
		end
		return r;
	endfunction

	task automatic send_write(logic [47:0] off, logic [31:0] len, logic [31:0] cnt,
			bit typed, prefix_t want);
		prefix_t p;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		write_offset <= off;
		write_length <= len;
		message_count <= cnt;
		p = merge_write(off, len, cnt);
		if (typed) begin
			if (p.prefix_end !== want.prefix_end) begin
				$error("prefix_end: expected %h, predictor %h", want.prefix_end,
					p.prefix_end);
				errors++;
			end
			if (p.prefix_messages !== want.prefix_messages) begin
				$error("prefix_messages: expected %h, predictor %h",
					want.prefix_messages, p.prefix_messages);
				errors++;
			end
			if (p.status !== want.status) begin
				$error("status: expected %0d, predictor %0d", want.status, p.status);
				errors++;
			end
			pending_prefix.push_back(want);
		end else begin
			pending_prefix.push_back(p);
		end
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	always @(posedge clk) begin
		prefix_t e;
		if (arst_n) begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
			if (out_valid && out_ready) begin
				if (pending_prefix.size() == 0) begin
					$error("unexpected result: prefix_end %h", prefix_end);
					errors++;
				end else begin
					e = pending_prefix.pop_front();
					if (prefix_end !== e.prefix_end) begin
						$error("prefix_end: expected %h, actual %h", e.prefix_end, prefix_end);
						errors++;
					end
					if (prefix_messages !== e.prefix_messages) begin
						$error("prefix_messages: expected %h, actual %h",
							e.prefix_messages, prefix_messages);
						errors++;
					end
					if (status !== e.status) begin
						$error("status: expected %0d, actual %0d", e.status, status);
						errors++;
					end
				end
			end
		end
	end

	function automatic row_t mk(logic [47:0] o, logic [31:0] l, logic [31:0] c,
			bit t = 0, logic [47:0] pe = 0, logic [47:0] pm = 0,
			status_t s = ST_MERGED);
		row_t r;
		r.offset = o;
		r.length = l;
		r.count = c;
		r.typed = t;
		r.want.prefix_end = pe;
		r.want.prefix_messages = pm;
		r.want.status = s;
		return r;
	endfunction

	task automatic random_phase(int n, int sidle, int ridle);
		logic [47:0] base, o;
		logic [31:0] l;
		int mode;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		base = 0;
		for (int i = 0; i < n; i++) begin
			if (i % 200 == 0) begin
				// fresh stream: clear table by resetting is not allowed; roll base forward
				base = tab_used > 0 ? tab_end[tab_used-1] + 48'd4096 : 48'd0;
			end
			mode = $urandom_range(99);
			l = $urandom_range(1, 64);
			if (mode < 60)
				o = base + 48'($urandom_range(0, 2000));
			else if (mode < 70)
				o = 48'($urandom_range(0, 600));
			else if (mode < 78) begin
				o = 48'({$urandom, $urandom});
				l = $urandom;
			end else if (mode < 84) begin
				o = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 100));
				l = $urandom_range(0, 200);
			end else if (mode < 90)
				l = 0;
			else begin
				o = base + 48'(64 * $urandom_range(0, 300));
				l = 32;
			end
			if (mode >= 90 || mode < 70 || mode >= 84 && mode < 90)
				o = (mode >= 84 && mode < 90) ? 48'({$urandom, $urandom}) : o;
			send_write(o, l, (mode % 7 == 0) ? 32'hFFFF_FFFF : $urandom, 0,
				'{prefix_end: '0, prefix_messages: '0, status: ST_MERGED});
		end
	endtask

	initial begin
		errors = 0;
		tab_used = 0;
		in_valid = 0;
		out_ready = 0;
		write_offset = 0;
		write_length = 0;
		message_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back(mk(48'd0, 32'd0, 32'd5, 1, 0, 0, ST_ZERO_LEN));
		rows.push_back(mk(48'hFFFF_FFFF_FFFF, 32'd1, 32'd1, 1, 0, 0, ST_OVERFLOW));
		rows.push_back(mk(48'hFFFF_FFFF_FFFE, 32'd1, 32'd1));
		rows.push_back(mk(48'hFFFF_0000_0001, 32'hFFFF_FFFF, 32'd0, 1, 0, 0, ST_OVERFLOW));
		rows.push_back(mk(48'd0, 32'd100, 32'hFFFF_FFFF, 1, 100, 48'hFFFF_FFFF));
		rows.push_back(mk(48'd100, 32'd10, 32'd1, 1, 110, 48'h1_0000_0000));
		rows.push_back(mk(48'd200, 32'd10, 32'd2));
		rows.push_back(mk(48'd50, 32'd200, 32'd3));
		rows.push_back(mk(48'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		rows.push_back(mk(48'd0, 32'd0, 32'd0));
		for (int i = 0; i < 68; i++)
			rows.push_back(mk(48'h1_0000_0000 + 48'(i) * 4, 32'd2, 32'd1));
		for (int i = 0; i < 10; i++)
			rows.push_back(mk(48'h1_0000_0000 + 48'(i) * 4 + 2, 32'd2, 32'd1));
		// four full-count merges at the prefix to grow its message count
		for (int i = 0; i < 4; i++)
			rows.push_back(mk(48'd0, 32'd1, 32'hFFFF_FFFF));
		foreach (rows[i])
			send_write(rows[i].offset, rows[i].length, rows[i].count, rows[i].typed,
				rows[i].want);

		recv_idle_pct = 84;
		random_phase(600, 11, 84);
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_prefix.size() != 0);
		random_phase(600, 84, 11);
		random_phase(600, 0, 0);
		in_valid <= 1'b0;

		do
			@(posedge clk);
		while (pending_prefix.size() != 0);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
